### hdl/prefix_code_table_decoder_macros.svh
// Assertion macros used by the prefix code table decoder RTL.
`ifndef PREFIX_CODE_TABLE_DECODER_MACROS_SVH
`define PREFIX_CODE_TABLE_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCTD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/pctd_pkg.sv
// Package with the types and constants of the prefix code table decoder.
package pctd_pkg;

	localparam int TABLE_ENTRIES_DEF   = 256;
	localparam int MAX_CODE_LENGTH_DEF = 32;

	localparam int SYM_W  = 8;
	localparam int LEN_W  = 6;
	localparam int CODE_W = 32;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_DECODE = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]        operation;
		logic [SYM_W-1:0]  entry_symbol;
		logic [LEN_W-1:0]  entry_length;
		logic [CODE_W-1:0] entry_code;
		logic              stream_bit;
	} item_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             error;
	} result_t;

	typedef struct packed {
		logic clear;
		logic append;
	} cam_ctl_t;

	typedef struct packed {
		logic             hit;
		logic [SYM_W-1:0] symbol;
	} cam_hit_t;

endpackage

### hdl/pctd_cam.sv
// Content-addressed code table: one compare cell per entry, lowest index wins.
module pctd_cam #(
	parameter int TABLE_ENTRIES   = pctd_pkg::TABLE_ENTRIES_DEF,
	parameter int MAX_CODE_LENGTH = pctd_pkg::MAX_CODE_LENGTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  pctd_pkg::cam_ctl_t                     ctl,
	input  pctd_pkg::item_t                        entry,
	input  logic [$clog2(MAX_CODE_LENGTH+1)-1:0]   look_len,
	input  logic [MAX_CODE_LENGTH-1:0]             look_bits,
	output pctd_pkg::cam_hit_t                     hit
);
	import pctd_pkg::*;

	localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
	localparam int IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int PLEN_W = $clog2(MAX_CODE_LENGTH + 1);
	localparam int LCMP_W = (PLEN_W > LEN_W) ? PLEN_W : LEN_W;
	localparam int CMP_W  = (MAX_CODE_LENGTH > CODE_W) ? MAX_CODE_LENGTH : CODE_W;

	function automatic logic [CODE_W-1:0] code_mask(input logic [LEN_W-1:0] len);
		logic [CODE_W-1:0] m;
		m = '1;
		if (len < LEN_W'(CODE_W)) begin
			m = ~(m << len);
		end
		return m;
	endfunction

	logic [SYM_W-1:0]         sym_q  [TABLE_ENTRIES];
	logic [LEN_W-1:0]         len_q  [TABLE_ENTRIES];
	logic [CODE_W-1:0]        code_q [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] shadow_q;
	logic [CNT_W-1:0]         count_q;

	logic [TABLE_ENTRIES-1:0] live;
	logic [TABLE_ENTRIES-1:0] dup_vec;
	logic [TABLE_ENTRIES-1:0] hit_vec;
	logic [TABLE_ENTRIES-1:0] sym_col [SYM_W];
	logic [CODE_W-1:0]        new_code;
	logic                     room;
	logic                     wr_en;
	logic [IDX_W-1:0]         wr_idx;

	// Codes are stored with the bits above their length already cleared.
	assign new_code = entry.entry_code & code_mask(entry.entry_length);
	assign room     = count_q < CNT_W'(TABLE_ENTRIES);
	assign wr_en    = ctl.append && room;
	assign wr_idx   = count_q[IDX_W-1:0];

	// An entry whose length and code repeat an earlier live entry can never
	// win, so it is marked shadowed when written. At most one unshadowed cell
	// then hits, and the symbol is a plain OR over the cells.
	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		assign live[i]    = CNT_W'(i) < count_q;
		assign dup_vec[i] = live[i] && (len_q[i] == entry.entry_length) &&
			(code_q[i] == new_code);
		assign hit_vec[i] = live[i] && !shadow_q[i] &&
			(LCMP_W'(len_q[i]) == LCMP_W'(look_len)) &&
			(CMP_W'(code_q[i]) == CMP_W'(look_bits));
		for (genvar b = 0; b < SYM_W; b++) begin : g_col
			assign sym_col[b][i] = sym_q[i][b];
		end
	end

	for (genvar b = 0; b < SYM_W; b++) begin : g_sym
		assign hit.symbol[b] = |(hit_vec & sym_col[b]);
	end
	assign hit.hit = |hit_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.clear) begin
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			sym_q[wr_idx]    <= entry.entry_symbol;
			len_q[wr_idx]    <= entry.entry_length;
			code_q[wr_idx]   <= new_code;
			shadow_q[wr_idx] <= |dup_vec;
		end
	end

endmodule

### hdl/prefix_code_table_decoder.sv
// Top level of the prefix code table decoder: input register, prefix state, result register.
// A result strobes on done once its item has passed the input register and the result register.
// Throughput: one item per cycle; busy is never raised, and every stream bit is
// checked against all table cells in parallel in the cycle after it is registered.
// Reset clears the entry count, the running prefix and the result strobe at once;
// table contents are not cleared and are only read below the entry count.
`include "prefix_code_table_decoder_macros.svh"

module prefix_code_table_decoder #(
	parameter int TABLE_ENTRIES   = pctd_pkg::TABLE_ENTRIES_DEF,
	parameter int MAX_CODE_LENGTH = pctd_pkg::MAX_CODE_LENGTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pctd_pkg::item_t   request,
	output logic              done,
	output pctd_pkg::result_t result
);
	import pctd_pkg::*;

	localparam int PLEN_W = $clog2(MAX_CODE_LENGTH + 1);

	// Input register: one item per cycle enters here.
	logic  v_s1;
	item_t item_s1;

	// Running prefix: the newest stream bit sits in bit zero.
	logic [MAX_CODE_LENGTH-1:0] prefix_q;
	logic [PLEN_W-1:0]          plen_q;

	// Result register.
	logic    done_q;
	result_t result_q;

	logic [MAX_CODE_LENGTH-1:0] bits_next;
	logic [PLEN_W-1:0]          plen_next;
	logic                       is_decode;
	logic                       at_limit;
	logic                       emit;
	cam_ctl_t                   ctl;
	cam_hit_t                   hit;

	// The receiver cannot stall and every item finishes in one pass, so the
	// block is always ready for the next item.
	assign busy = 1'b0;

	assign is_decode  = v_s1 && (item_s1.operation == OP_DECODE);
	assign ctl.clear  = v_s1 && (item_s1.operation == OP_CLEAR);
	assign ctl.append = v_s1 && (item_s1.operation == OP_APPEND);

	// The prefix always holds fewer than MAX_CODE_LENGTH bits here, so the
	// shift never drops a live bit.
	assign bits_next = {prefix_q[MAX_CODE_LENGTH-2:0], item_s1.stream_bit};
	assign plen_next = plen_q + PLEN_W'(1);
	assign at_limit  = plen_next == PLEN_W'(MAX_CODE_LENGTH);

	// A match wins over the length limit; either one ends the current code.
	assign emit = is_decode && (hit.hit || at_limit);

	pctd_cam #(
		.TABLE_ENTRIES  (TABLE_ENTRIES),
		.MAX_CODE_LENGTH(MAX_CODE_LENGTH)
	) u_cam (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.entry    (item_s1),
		.look_len (plen_next),
		.look_bits(bits_next),
		.hit      (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			prefix_q <= '0;
			plen_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			v_s1   <= start && !busy;
			done_q <= emit;
			if (ctl.clear || emit) begin
				prefix_q <= '0;
				plen_q   <= '0;
			end else if (is_decode) begin
				prefix_q <= bits_next;
				plen_q   <= plen_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= request;
		end
		if (emit) begin
			result_q.symbol <= hit.hit ? hit.symbol : '0;
			result_q.error  <= !hit.hit;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`PCTD_ASSERT_NEXT(a_result_needs_decode, clk, arst_n, !is_decode, !done_q, "result without a decode item")
	`PCTD_ASSERT_NOW(a_prefix_empty_on_result, clk, arst_n, done_q, plen_q == '0, "prefix not cleared with result")
	`PCTD_ASSERT_NOW(a_prefix_below_limit, clk, arst_n, 1'b1, plen_q < PLEN_W'(MAX_CODE_LENGTH), "prefix length reached limit")
	`PCTD_ASSERT_NOW(a_error_symbol_zero, clk, arst_n, done_q && result_q.error, result_q.symbol == '0, "error result carries a symbol")

endmodule

### bench/prefix_code_table_decoder_checker.sv
// Checker that follows the decoder's items, computes each decoded symbol and compares results.
`timescale 1ns / 100ps

module prefix_code_table_decoder_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  pctd_pkg::item_t   request,
	input  logic              done,
	input  pctd_pkg::result_t result,
	output int                failures,
	output int                outstanding
);
	import pctd_pkg::*;

	logic [SYM_W-1:0]  sym_store  [TABLE_ENTRIES_DEF];
	logic [LEN_W-1:0]  len_store  [TABLE_ENTRIES_DEF];
	logic [CODE_W-1:0] code_store [TABLE_ENTRIES_DEF];
	int                entries;
	logic [63:0]       prefix_acc;
	int                prefix_len;
	result_t           symbols_due[$];
	result_t           due;
	int                fail_cnt;

	// Applies one accepted item to the local copy of the table and the prefix.
	task automatic decode_model(input item_t it);
		logic [63:0] mask;
		bit          hit;
		result_t     res;
		hit = 1'b0;
		res = '0;
		case (it.operation)
			OP_CLEAR: begin
				entries = 0;
				prefix_acc = '0;
				prefix_len = 0;
			end
			OP_APPEND: begin
				if (entries < TABLE_ENTRIES_DEF) begin
					sym_store[entries] = it.entry_symbol;
					len_store[entries] = it.entry_length;
					code_store[entries] = it.entry_code;
					entries++;
				end
			end
			OP_DECODE: begin
				prefix_acc = {prefix_acc[62:0], it.stream_bit};
				prefix_len++;
				// The lowest matching index wins.
				for (int i = 0; i < entries; i++) begin
					mask = (64'd1 << len_store[i]) - 64'd1;
					if (!hit && int'(len_store[i]) == prefix_len &&
							((({32'd0, code_store[i]}) ^ prefix_acc) & mask) == '0) begin
						hit = 1'b1;
						res.symbol = sym_store[i];
						res.error = 1'b0;
					end
				end
				if (!hit && prefix_len >= MAX_CODE_LENGTH_DEF) begin
					hit = 1'b1;
					res.symbol = '0;
					res.error = 1'b1;
				end
				if (hit) begin
					symbols_due = {symbols_due, res};
					prefix_acc = '0;
					prefix_len = 0;
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries = 0;
			prefix_acc = '0;
			prefix_len = 0;
			symbols_due.delete();
			fail_cnt = 0;
			failures <= 0;
			outstanding <= 0;
		end else begin
			if (done) begin
				if (symbols_due.size() == 0) begin
					fail_cnt++;
					$display("%0t: result with nothing owed: symbol %02h error %0b",
						$time, result.symbol, result.error);
				end else begin
					due = symbols_due.pop_front();
					if (result.symbol !== due.symbol) begin
						fail_cnt++;
						$display("%0t: symbol mismatch: expected %02h, got %02h",
							$time, due.symbol, result.symbol);
					end
					if (result.error !== due.error) begin
						fail_cnt++;
						$display("%0t: error flag mismatch: expected %0b, got %0b",
							$time, due.error, result.error);
					end
				end
			end
			if (start && !busy)
				decode_model(request);
			failures <= fail_cnt;
			outstanding <= symbols_due.size();
		end
	end

endmodule

### bench/tb_prefix_code_table_decoder.sv
// Testbench top for the prefix code table decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_prefix_code_table_decoder;
	import pctd_pkg::*;

	// The package leaves the fourth operation code unnamed; the block must ignore it.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int RANDOM_ITEMS = 1450;
	// Items at the end of the random part that are sent back to back.
	localparam int CALM_TAIL    = 200;
	// Cycles without any accepted item or result before the run is declared hung.
	localparam int STALL_LIMIT  = 400;
	// Cycles watched after the last owed result, to catch stray results.
	localparam int DRAIN_CYCLES = 6;

	// Kinds of table and stream that one random session builds.
	typedef enum int {
		SESS_FULL,
		SESS_CHAIN,
		SESS_TREE,
		SESS_HOLEY,
		SESS_EMPTY
	} session_t;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	logic    done;
	item_t   request;
	result_t result;
	int      failures;
	int      outstanding;
	int      items_sent;
	int      quiet_cycles = 0;
	bit      gaps_on;

	// Leaves of the code tree of the current session.
	logic [31:0] leaf_code[$];
	int          leaf_len[$];

	prefix_code_table_decoder i_dut (
		.clk,
		.arst_n,
		.start,
		.busy,
		.request,
		.done,
		.result
	);

	prefix_code_table_decoder_checker i_checker (
		.clk,
		.arst_n,
		.start,
		.busy,
		.request,
		.done,
		.result,
		.failures,
		.outstanding
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// The watchdog restarts whenever an item or a result is accepted.
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_prefix_code_table_decoder NOT OK");
			$finish;
		end
	end

	// Sends one item, possibly after a burst of idle cycles. Inputs change on the falling
	// edge, and the item counts as taken at the first rising edge with busy low.
	task automatic push_item(input logic [1:0] op, input logic [7:0] sym,
			input logic [5:0] len, input logic [31:0] code, input logic sbit);
		item_t it;
		it.operation = op;
		it.entry_symbol = sym;
		it.entry_length = len;
		it.entry_code = code;
		it.stream_bit = sbit;
		if (gaps_on && items_sent < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		start <= 1'b1;
		request <= it;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	// Fields that an operation does not use get random values.
	task automatic push_bit(input logic sbit);
		push_item(OP_DECODE, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)), $urandom,
			sbit);
	endtask

	task automatic push_entry(input logic [7:0] sym, input logic [5:0] len,
			input logic [31:0] code);
		push_item(OP_APPEND, sym, len, code, 1'($urandom_range(0, 1)));
	endtask

	task automatic push_clear();
		push_item(OP_CLEAR, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)), $urandom,
			1'($urandom_range(0, 1)));
	endtask

	task automatic push_unused();
		push_item(OP_UNUSED, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)), $urandom,
			1'($urandom_range(0, 1)));
	endtask

	// One session: clear, then load a code table built from a random binary tree and feed a
	// stream made of its codewords with a little noise; an empty session feeds random bits.
	task automatic run_session(input session_t kind);
		int          leaves;
		int          j;
		int          words;
		int          pick;
		int          tl;
		logic [31:0] c;
		logic [31:0] tc;
		leaf_code.delete();
		leaf_len.delete();
		gaps_on = ($urandom_range(0, 3) != 0);
		push_clear();

		// Without a table every 32 bits end in an error.
		if (kind == SESS_EMPTY) begin
			repeat ($urandom_range(33, 100)) push_bit(1'($urandom_range(0, 1)));
			return;
		end

		if (kind == SESS_FULL)
			leaves = TABLE_ENTRIES_DEF;
		else if (kind == SESS_CHAIN)
			leaves = $urandom_range(20, 33);
		else
			leaves = $urandom_range(2, 24);

		// Grow the tree by splitting leaves. A chain always splits the newest leaf, so
		// with 33 leaves its two deepest codes are exactly the maximum code length.
		leaf_code = '{32'd0, 32'd1};
		leaf_len = '{1, 1};
		while (leaf_len.size() < leaves) begin
			if (kind == SESS_CHAIN)
				j = leaf_len.size() - 1;
			else
				j = $urandom_range(0, leaf_len.size() - 1);
			if (leaf_len[j] < MAX_CODE_LENGTH_DEF) begin
				c = leaf_code[j] << 1;
				leaf_code[j] = c;
				leaf_len[j]++;
				leaf_code = {leaf_code, c | 32'd1};
				leaf_len = {leaf_len, leaf_len[j]};
			end
		end

		for (int i = leaf_len.size() - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tc = leaf_code[i];
			leaf_code[i] = leaf_code[j];
			leaf_code[j] = tc;
			tl = leaf_len[i];
			leaf_len[i] = leaf_len[j];
			leaf_len[j] = tl;
		end

		// Load the table. A holey table leaves out some codes so that the stream walks
		// into them and runs to the length limit. Bits above the code length are junk
		// half of the time.
		foreach (leaf_len[i]) begin
			if (kind == SESS_HOLEY && $urandom_range(0, 3) == 0)
				continue;
			c = leaf_code[i];
			if (leaf_len[i] < 32 && $urandom_range(0, 1))
				c = c | ($urandom << leaf_len[i]);
			push_entry(8'($urandom_range(0, 255)), 6'(leaf_len[i]), c);
			case ($urandom_range(0, 15))
				// A zero length entry can never match.
				0: push_entry(8'($urandom_range(0, 255)), 6'd0, $urandom);
				// Nor can one longer than the limit.
				1: push_entry(8'($urandom_range(0, 255)), 6'($urandom_range(33, 63)), $urandom);
				// A copy under a later index loses to the first one.
				2: push_entry(8'($urandom_range(0, 255)), 6'(leaf_len[i]), c);
				default: ;
			endcase
		end

		// Short codes sent to a full table must be dropped; if one got in it would
		// steal matches from the real codes.
		if (kind == SESS_FULL)
			repeat ($urandom_range(1, 4))
				push_entry(8'($urandom_range(0, 255)), 6'($urandom_range(1, 4)), $urandom);

		words = (kind == SESS_FULL) ? 30 : $urandom_range(10, 40);
		repeat (words) begin
			// The stream stops once the run has sent its share of items.
			if (items_sent >= RANDOM_ITEMS)
				break;
			pick = $urandom_range(0, leaf_len.size() - 1);
			for (int b = leaf_len[pick] - 1; b >= 0; b--) begin
				push_bit(leaf_code[pick][b]);
				// Noise inside a codeword: a stray bit knocks the stream out of step, while
				// an ignored code or a late entry must leave the running prefix alone.
				case ($urandom_range(0, 47))
					0: push_bit(1'($urandom_range(0, 1)));
					1: push_unused();
					2: push_entry(8'($urandom_range(0, 255)), 6'($urandom_range(1, 8)),
						$urandom);
					default: ;
				endcase
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		gaps_on = 1'b1;
		items_sent = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part. Table: index 0 is "0" with junk above bit 0, index 1 has zero
		// length, indexes 2 and 3 both hold "10", index 4 is longer than the limit and
		// index 5 is "110".
		push_clear();
		push_entry(8'hA5, 6'd1, 32'hFFFF_FFFE);
		push_entry(8'h00, 6'd0, 32'h0000_0000);
		push_entry(8'h11, 6'd2, 32'h0000_0002);
		push_entry(8'h22, 6'd2, 32'h0000_0002);
		push_entry(8'h33, 6'd40, 32'hFFFF_FFFF);
		push_entry(8'hFF, 6'd3, 32'h0000_0006);
		push_unused();
		push_bit(1'b0);
		push_bit(1'b1);
		push_bit(1'b0);
		push_bit(1'b1);
		push_bit(1'b1);
		push_bit(1'b0);
		// An append in the middle of a codeword keeps the prefix, and the new entry
		// then completes it.
		push_bit(1'b1);
		push_entry(8'h44, 6'd3, 32'h0000_0007);
		push_bit(1'b1);
		push_bit(1'b1);
		// A clear drops a half-built prefix; with the table gone the next bit gives nothing.
		push_bit(1'b1);
		push_clear();
		push_bit(1'b0);

		// Random part. The first session fills the table to the brim.
		items_sent = 0;
		run_session(SESS_FULL);
		while (items_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0:       run_session(SESS_EMPTY);
				1, 2:    run_session(SESS_CHAIN);
				3, 4:    run_session(SESS_HOLEY);
				default: run_session(SESS_TREE);
			endcase
		end
		start <= 1'b0;

		// Wait for every owed result, then keep watching for anything unexpected.
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("tb_prefix_code_table_decoder OK");
		else
			$display("tb_prefix_code_table_decoder NOT OK");
		$finish;
	end

endmodule
